FILE: rtl/core/lvm_pkg.sv
// Shared types, constants and helpers for the look-at view matrix core.
`default_nettype none
package lvm_pkg;

  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
  localparam int unsigned QDEPTH = 2;

  // One queued item: forward difference and up hint
  typedef struct packed {
    logic [2:0][32:0] diff;
    logic [2:0][31:0] up;
  } item_t;

  // Finished matrix, handed from the compute engine to the emitter
  typedef struct packed {
    logic [2:0][31:0] side;
    logic [2:0][31:0] tup;
    logic [2:0][31:0] nfwd;
    logic             degen;
  } mat_t;

  typedef enum logic [2:0] {
    NS_IDLE, NS_SHIFT, NS_SQ, NS_ROOT, NS_DLOAD, NS_DIV
  } norm_state_t;

  typedef enum logic [2:0] {
    BS_IDLE, BS_NFWD, BS_X1, BS_NSIDE, BS_X2, BS_RND, BS_HAND
  } back_state_t;

  // Cross product step order: r0 = a1*b2 - a2*b1, r1 = a2*b0 - a0*b2, r2 = a0*b1 - a1*b0
  function automatic logic [1:0] xa_sel(input logic [2:0] s);
    logic [1:0] r;
    unique case (s)
      3'd0:    r = 2'd1;
      3'd1:    r = 2'd2;
      3'd2:    r = 2'd2;
      3'd3:    r = 2'd0;
      3'd4:    r = 2'd0;
      3'd5:    r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] xb_sel(input logic [2:0] s);
    logic [1:0] r;
    unique case (s)
      3'd0:    r = 2'd2;
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd0;
      3'd3:    r = 2'd2;
      3'd4:    r = 2'd1;
      3'd5:    r = 2'd0;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // Q4.60 to Q2.30, halves away from zero, saturating
  function automatic logic [31:0] round_q30(input logic [63:0] v);
    logic [63:0] mag;
    logic [63:0] sm;
    logic [33:0] m;
    logic [31:0] r;
    mag = v[63] ? (64'd0 - v) : v;
    sm  = mag + 64'h2000_0000;
    m   = sm[63:30];
    if (m > 34'h0_7FFF_FFFF) begin
      r = v[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r = v[63] ? (32'd0 - m[31:0]) : m[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/lvm_front.sv
// Input stage: forms the forward difference and queues items for the engine.
`default_nettype none
module lvm_front import lvm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_eye_x,
  input  wire logic signed [31:0] in_eye_y,
  input  wire logic signed [31:0] in_eye_z,
  input  wire logic signed [31:0] in_target_x,
  input  wire logic signed [31:0] in_target_y,
  input  wire logic signed [31:0] in_target_z,
  input  wire logic signed [31:0] in_up_x,
  input  wire logic signed [31:0] in_up_y,
  input  wire logic signed [31:0] in_up_z,
  output logic                    q_valid,
  output item_t                   q_item,
  input  wire logic               q_pop
);

  item_t      mem_r [QDEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  item_t      push_item;
  logic       push;

  // Exact 33-bit differences
  always_comb begin
    push_item.diff[0] = {in_target_x[31], in_target_x} - {in_eye_x[31], in_eye_x};
    push_item.diff[1] = {in_target_y[31], in_target_y} - {in_eye_y[31], in_eye_y};
    push_item.diff[2] = {in_target_z[31], in_target_z} - {in_eye_z[31], in_eye_z};
    push_item.up[0]   = in_up_x;
    push_item.up[1]   = in_up_y;
    push_item.up[2]   = in_up_z;
  end

  assign in_stall = (count_r == 2'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = mem_r[rd_ptr_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/lvm_norm.sv
// Sequential vector normalizer: shift, sum of squares, bit-serial sqrt and divide.
`default_nettype none
module lvm_norm import lvm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [2:0][63:0] vin,
  output logic                  done,
  output logic                  ok,
  output logic [2:0][31:0]      res
);

  norm_state_t      state_r, state_nxt;
  logic [2:0]       neg_r;
  logic [2:0][63:0] m_r;
  logic [59:0]      prod_r;
  logic [61:0]      sum_r;
  logic [61:0]      rem_r;
  logic [61:0]      root_r;
  logic [61:0]      bit_r;
  logic [30:0]      len_r;
  logic [30:0]      drem_r;
  logic [30:0]      dlow_r;
  logic [30:0]      q_r;
  logic [4:0]       cnt_r;
  logic [1:0]       idx_r;
  logic             done_r;
  logic             ok_r;
  logic [2:0][31:0] res_r;

  logic [63:0]      orv;
  logic             all_zero;
  logic [61:0]      sum_nxt;
  logic [61:0]      rtry;
  logic [60:0]      num;
  logic [31:0]      dtry;
  logic             qbit;
  logic [30:0]      q_fin;

  assign orv      = m_r[0] | m_r[1] | m_r[2];
  assign all_zero = (vin[0] == 64'd0) && (vin[1] == 64'd0) && (vin[2] == 64'd0);
  assign sum_nxt  = sum_r + {2'b00, prod_r};
  assign rtry     = root_r + bit_r;
  assign num      = {1'b0, m_r[idx_r][29:0], 30'd0} + {30'd0, 1'b0, len_r[30:1]};
  assign dtry     = {drem_r, dlow_r[30]};
  assign qbit     = (dtry >= {1'b0, len_r});
  assign q_fin    = {q_r[29:0], qbit};

  assign done = done_r;
  assign ok   = ok_r;
  assign res  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= NS_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == NS_IDLE && start && all_zero) ||
                 (state_r == NS_DIV && cnt_r == 5'd30 && idx_r == 2'd2);
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      NS_IDLE:  if (start && !all_zero) state_nxt = NS_SHIFT;
      NS_SHIFT: if (orv[63:30] == 34'd0 && orv[29]) state_nxt = NS_SQ;
      NS_SQ:    if (cnt_r == 5'd3) state_nxt = NS_ROOT;
      NS_ROOT:  if (cnt_r == 5'd30) state_nxt = NS_DLOAD;
      NS_DLOAD: state_nxt = NS_DIV;
      NS_DIV:   if (cnt_r == 5'd30) state_nxt = (idx_r == 2'd2) ? NS_IDLE : NS_DLOAD;
      default:  state_nxt = NS_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      NS_IDLE: begin
        if (start) begin
          for (int i = 0; i < 3; i++) begin
            neg_r[i] <= vin[i][63];
            m_r[i]   <= vin[i][63] ? (64'd0 - vin[i]) : vin[i];
          end
          ok_r <= !all_zero;
          if (all_zero) res_r <= '0;
        end
      end
      NS_SHIFT: begin
        // Bring the largest magnitude into [2^29, 2^30)
        if (orv[63:30] != 34'd0) begin
          for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 1;
        end else if (!orv[29]) begin
          for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] << 1;
        end else begin
          cnt_r  <= 5'd0;
          sum_r  <= '0;
          prod_r <= '0;
        end
      end
      NS_SQ: begin
        if (cnt_r != 5'd3) begin
          prod_r <= m_r[cnt_r[1:0]][29:0] * m_r[cnt_r[1:0]][29:0];
        end
        sum_r <= sum_nxt;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd3) begin
          rem_r  <= sum_nxt;
          root_r <= '0;
          bit_r  <= 62'd1 << 60;
          cnt_r  <= 5'd0;
        end
      end
      NS_ROOT: begin
        // One result bit per cycle
        if (rem_r >= rtry) begin
          rem_r  <= rem_r - rtry;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd30) begin
          idx_r <= 2'd0;
          len_r <= (rem_r >= rtry) ? 31'((root_r >> 1) + bit_r) : 31'(root_r >> 1);
        end
      end
      NS_DLOAD: begin
        drem_r <= {1'b0, num[60:31]};
        dlow_r <= num[30:0];
        q_r    <= '0;
        cnt_r  <= 5'd0;
      end
      NS_DIV: begin
        // Restoring divide, one quotient bit per cycle
        drem_r <= qbit ? 31'(dtry - {1'b0, len_r}) : dtry[30:0];
        dlow_r <= dlow_r << 1;
        q_r    <= q_fin;
        cnt_r  <= cnt_r + 5'd1;
        if (cnt_r == 5'd30) begin
          res_r[idx_r] <= neg_r[idx_r] ? (32'd0 - {1'b0, q_fin}) : {1'b0, q_fin};
          idx_r        <= idx_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/lvm_back.sv
// Compute engine: normalizes forward, forms side and true-up, builds the matrix.
`default_nettype none
module lvm_back import lvm_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  input  wire item_t q_item,
  output logic       q_pop,
  output logic       m_valid,
  output mat_t       m_data,
  input  wire logic  m_take
);

  back_state_t      state_r, state_nxt;
  logic             start_r;
  logic [2:0][63:0] vin_r;
  logic [2:0][31:0] up_r;
  logic [2:0][31:0] fwd_r;
  logic [2:0][31:0] xa_r;
  logic [2:0][31:0] xb_r;
  logic [2:0][63:0] acc_r;
  logic [63:0]      prod_r;
  logic [2:0]       cnt_r;
  logic             okf_r;
  logic             oks_r;
  mat_t             mat_r;

  logic             n_done;
  logic             n_ok;
  logic [2:0][31:0] n_res;
  logic [2:0][63:0] acc_nxt;
  logic [2:0]       cm1;

  lvm_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .vin   (vin_r),
    .done  (n_done),
    .ok    (n_ok),
    .res   (n_res)
  );

  assign q_pop   = (state_r == BS_IDLE) && q_valid;
  assign m_valid = (state_r == BS_HAND);
  assign m_data  = mat_r;
  assign cm1     = cnt_r - 3'd1;

  // Accumulate the product from the previous step into its cross term
  always_comb begin
    acc_nxt = acc_r;
    if (cnt_r != 3'd0) begin
      if (cm1[0]) acc_nxt[cm1[2:1]] = acc_r[cm1[2:1]] - prod_r;
      else        acc_nxt[cm1[2:1]] = acc_r[cm1[2:1]] + prod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= q_pop || (state_r == BS_X1 && cnt_r == 3'd6);
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BS_IDLE:  if (q_valid) state_nxt = BS_NFWD;
      BS_NFWD:  if (n_done) state_nxt = BS_X1;
      BS_X1:    if (cnt_r == 3'd6) state_nxt = BS_NSIDE;
      BS_NSIDE: if (n_done) state_nxt = BS_X2;
      BS_X2:    if (cnt_r == 3'd6) state_nxt = BS_RND;
      BS_RND:   state_nxt = BS_HAND;
      BS_HAND:  if (m_take) state_nxt = BS_IDLE;
      default:  state_nxt = BS_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      BS_IDLE: begin
        if (q_valid) begin
          for (int i = 0; i < 3; i++) begin
            vin_r[i] <= {{31{q_item.diff[i][32]}}, q_item.diff[i]};
          end
          up_r <= q_item.up;
        end
      end
      BS_NFWD: begin
        if (n_done) begin
          fwd_r <= n_res;
          okf_r <= n_ok;
          xa_r  <= n_res;
          xb_r  <= up_r;
          acc_r <= '0;
          cnt_r <= 3'd0;
        end
      end
      BS_X1, BS_X2: begin
        // One signed 32x32 product per cycle
        if (cnt_r != 3'd6) begin
          prod_r <= 64'($signed(xa_r[xa_sel(cnt_r)]) * $signed(xb_r[xb_sel(cnt_r)]));
        end
        acc_r <= acc_nxt;
        cnt_r <= cnt_r + 3'd1;
        if (state_r == BS_X1 && cnt_r == 3'd6) vin_r <= acc_nxt;
      end
      BS_NSIDE: begin
        if (n_done) begin
          mat_r.side <= n_res;
          oks_r      <= n_ok;
          xa_r       <= n_res;
          xb_r       <= fwd_r;
          acc_r      <= '0;
          cnt_r      <= 3'd0;
        end
      end
      BS_RND: begin
        for (int i = 0; i < 3; i++) begin
          mat_r.tup[i]  <= round_q30(acc_r[i]);
          mat_r.nfwd[i] <= 32'd0 - fwd_r[i];
        end
        mat_r.degen <= !okf_r || !oks_r;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/lvm_emit.sv
// Output stage: holds one matrix and sends it as four element groups.
`default_nettype none
module lvm_emit import lvm_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  m_valid,
  input  wire mat_t  m_data,
  output logic       m_take,
  output logic       out_valid,
  input  wire logic  out_stall,
  output logic [1:0] out_group_index,
  output logic signed [31:0] out_elem_0,
  output logic signed [31:0] out_elem_1,
  output logic signed [31:0] out_elem_2,
  output logic signed [31:0] out_elem_3,
  output logic       out_last_group,
  output logic       out_degenerate
);

  mat_t       mat_r;
  logic       busy_r;
  logic [1:0] g_r;
  logic       xfer;
  logic       last;

  assign xfer   = busy_r && !out_stall;
  assign last   = (g_r == 2'd3);
  assign m_take = m_valid && (!busy_r || (xfer && last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      g_r    <= 2'd0;
    end else if (m_take) begin
      busy_r <= 1'b1;
      g_r    <= 2'd0;
    end else if (xfer) begin
      if (last) busy_r <= 1'b0;
      g_r <= g_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_take) mat_r <= m_data;
  end

  // Group contents
  always_comb begin
    out_valid       = busy_r;
    out_group_index = g_r;
    out_last_group  = last;
    out_degenerate  = mat_r.degen;
    if (last) begin
      out_elem_0 = '0;
      out_elem_1 = '0;
      out_elem_2 = '0;
      out_elem_3 = ONE_Q30;
    end else begin
      out_elem_0 = mat_r.side[g_r];
      out_elem_1 = mat_r.tup[g_r];
      out_elem_2 = mat_r.nfwd[g_r];
      out_elem_3 = '0;
    end
  end

`ifndef NO_ASSERTIONS
  a_group_step: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && !last |=> busy_r && g_r == $past(g_r) + 2'd1)
    else $error("group did not advance after transfer");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    m_take |-> !busy_r || (last && !out_stall))
    else $error("matrix loaded over one still in flight");
  a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
    m_take |=> busy_r && g_r == 2'd0)
    else $error("loaded matrix does not start at group zero");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/lookat_view_matrix_core.sv
// Look-at view matrix core: top level joining front queue, compute engine and emitter.
// Path: an item leaves the front queue, then the normalizer runs twice (forward, then side),
//   each run with shift steps, sum of squares, root and three divides; a zero vector skips them.
// Throughput: the engine works on one item at a time; the four groups leave on back-to-back
//   cycles while out_stall is low, and the engine already works on the next queued item.
// Reset: rst_n synchronous, active low; clears queue, sequencers and output valid.
`default_nettype none
module lookat_view_matrix_core import lvm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_eye_x,
  input  wire logic signed [31:0] in_eye_y,
  input  wire logic signed [31:0] in_eye_z,
  input  wire logic signed [31:0] in_target_x,
  input  wire logic signed [31:0] in_target_y,
  input  wire logic signed [31:0] in_target_z,
  input  wire logic signed [31:0] in_up_x,
  input  wire logic signed [31:0] in_up_y,
  input  wire logic signed [31:0] in_up_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_group_index,
  output logic signed [31:0]      out_elem_0,
  output logic signed [31:0]      out_elem_1,
  output logic signed [31:0]      out_elem_2,
  output logic signed [31:0]      out_elem_3,
  output logic                    out_last_group,
  output logic                    out_degenerate
);

  logic  q_valid;
  item_t q_item;
  logic  q_pop;
  logic  m_valid;
  mat_t  m_data;
  logic  m_take;

  lvm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_eye_x    (in_eye_x),
    .in_eye_y    (in_eye_y),
    .in_eye_z    (in_eye_z),
    .in_target_x (in_target_x),
    .in_target_y (in_target_y),
    .in_target_z (in_target_z),
    .in_up_x     (in_up_x),
    .in_up_y     (in_up_y),
    .in_up_z     (in_up_z),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  lvm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .m_valid (m_valid),
    .m_data  (m_data),
    .m_take  (m_take)
  );

  lvm_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .m_valid         (m_valid),
    .m_data          (m_data),
    .m_take          (m_take),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_group_index (out_group_index),
    .out_elem_0      (out_elem_0),
    .out_elem_1      (out_elem_1),
    .out_elem_2      (out_elem_2),
    .out_elem_3      (out_elem_3),
    .out_last_group  (out_last_group),
    .out_degenerate  (out_degenerate)
  );

endmodule
`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for the look-at view matrix core.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import lvm_pkg::*;

  localparam int N_RANDOM    = 350;
  localparam int CYCLE_LIMIT = 900000;
  localparam int DRAIN_WAIT  = 500;
  localparam int HOLD_CYCLES = 2500;

  typedef longint vec3_t [3];

  typedef struct {
    logic signed [31:0] eye [3];
    logic signed [31:0] tgt [3];
    logic signed [31:0] up  [3];
    bit                 zero_fwd;  // expected matrix typed in: eye equals target
  } view_req_t;

  typedef struct {
    logic [1:0]         grp;
    logic signed [31:0] e [4];
    logic               last;
    logic               degen;
  } mat_group_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_eye_x = '0, in_eye_y = '0, in_eye_z = '0;
  logic signed [31:0] in_target_x = '0, in_target_y = '0, in_target_z = '0;
  logic signed [31:0] in_up_x = '0, in_up_y = '0, in_up_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_group_index;
  logic signed [31:0] out_elem_0, out_elem_1, out_elem_2, out_elem_3;
  logic out_last_group, out_degenerate;

  mat_group_t groups_due [$];
  view_req_t  dir_rows [$];
  int errors = 0;
  int groups_seen = 0;
  int items_sent = 0;
  int degen_seen = 0;
  int cycles = 0;
  bit in_quiet = 1'b0;
  bit out_quiet = 1'b0;
  bit hold_done = 1'b0;
  int hold_cnt = 0;

  lookat_view_matrix_core dut (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_eye_x, .in_eye_y, .in_eye_z,
    .in_target_x, .in_target_y, .in_target_z,
    .in_up_x, .in_up_y, .in_up_z,
    .out_valid, .out_stall, .out_group_index,
    .out_elem_0, .out_elem_1, .out_elem_2, .out_elem_3,
    .out_last_group, .out_degenerate
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint unsigned mag_of(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Unit vector in Q2.30; returns 0 on zero length
  function automatic bit unit_vec(input vec3_t v, output vec3_t u);
    longint unsigned m [3];
    longint unsigned mx, sum, len, q;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag_of(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      u = '{0, 0, 0};
      return 1'b0;
    end
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 30) + (len >> 1)) / len;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic vec3_t cross_prod(vec3_t a, vec3_t b);
    vec3_t r;
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
    return r;
  endfunction

  // Q4.60 to Q2.30, halves away from zero, saturating
  function automatic logic signed [31:0] to_q30(longint v);
    longint unsigned m;
    m = (mag_of(v) + (64'd1 << 29)) >> 30;
    if (m > 64'h7FFF_FFFF) m = v < 0 ? 64'h8000_0000 : 64'h7FFF_FFFF;
    return v < 0 ? 32'(-longint'(m)) : 32'(m);
  endfunction

  // Push the four groups of the view matrix for one transfer
  task automatic queue_view_matrix(view_req_t r);
    vec3_t diff, upv, fwd, side, tup;
    bit ok_f, ok_s;
    mat_group_t g;
    for (int i = 0; i < 3; i++) begin
      diff[i] = longint'(r.tgt[i]) - longint'(r.eye[i]);
      upv[i] = longint'(r.up[i]);
    end
    ok_f = unit_vec(diff, fwd);
    ok_s = unit_vec(cross_prod(fwd, upv), side);
    tup = cross_prod(side, fwd);
    for (int k = 0; k < 4; k++) begin
      g.grp = 2'(k);
      g.last = (k == 3);
      g.degen = !(ok_f && ok_s);
      if (r.zero_fwd) begin
        // zero forward: every axis is zero
        g.e = '{32'sd0, 32'sd0, 32'sd0, 32'sd0};
        g.degen = 1'b1;
      end else if (k < 3) begin
        g.e = '{32'(side[k]), to_q30(tup[k]), 32'(-fwd[k]), 32'sd0};
      end else begin
        g.e = '{32'sd0, 32'sd0, 32'sd0, 32'sd0};
      end
      if (k == 3) g.e[3] = ONE_Q30;
      groups_due.push_back(g);
    end
  endtask

  task automatic send_view(view_req_t r);
    while (!in_quiet && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_eye_x <= r.eye[0];    in_eye_y <= r.eye[1];    in_eye_z <= r.eye[2];
    in_target_x <= r.tgt[0]; in_target_y <= r.tgt[1]; in_target_z <= r.tgt[2];
    in_up_x <= r.up[0];      in_up_y <= r.up[1];      in_up_z <= r.up[2];
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    queue_view_matrix(r);
    items_sent++;
  endtask

  function automatic view_req_t mk(int ex, int ey, int ez, int tx, int ty, int tz,
                                   int ux, int uy, int uz, bit zf);
    view_req_t r;
    r.eye = '{ex, ey, ez};
    r.tgt = '{tx, ty, tz};
    r.up  = '{ux, uy, uz};
    r.zero_fwd = zf;
    return r;
  endfunction

  function automatic logic signed [31:0] small_val();
    return $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
  endfunction

  function automatic view_req_t rand_view();
    view_req_t r;
    int sel, k;
    sel = $urandom_range(99);
    r.zero_fwd = 1'b0;
    for (int i = 0; i < 3; i++) begin
      r.eye[i] = $urandom;
      r.tgt[i] = $urandom;
      r.up[i]  = $urandom;
    end
    if (sel >= 45 && sel < 70) begin
      for (int i = 0; i < 3; i++) begin
        r.eye[i] = small_val();
        r.tgt[i] = small_val();
        r.up[i]  = small_val();
      end
    end else if (sel >= 70 && sel < 82) begin
      // up parallel to forward, or zero: side collapses
      k = int'($urandom_range(6)) - 3;
      for (int i = 0; i < 3; i++) begin
        r.eye[i] = small_val();
        r.tgt[i] = r.eye[i] + small_val();
        r.up[i]  = (r.tgt[i] - r.eye[i]) * k;
      end
    end else if (sel >= 82 && sel < 90) begin
      r.tgt = r.eye;
    end
    return r;
  endfunction

  // Result checker
  always @(posedge clk) begin
    mat_group_t g;
    if (rst_n && out_valid && !out_stall) begin
      groups_seen++;
      if (groups_due.size() == 0) begin
        $error("unexpected group transfer, index %0d", out_group_index);
        errors++;
      end else begin
        g = groups_due.pop_front();
        if (out_group_index !== g.grp) begin
          $error("group_index: expected %0d, got %0d", g.grp, out_group_index);
          errors++;
        end
        if (out_elem_0 !== g.e[0]) begin
          $error("elem_0: expected %h, got %h", g.e[0], out_elem_0);
          errors++;
        end
        if (out_elem_1 !== g.e[1]) begin
          $error("elem_1: expected %h, got %h", g.e[1], out_elem_1);
          errors++;
        end
        if (out_elem_2 !== g.e[2]) begin
          $error("elem_2: expected %h, got %h", g.e[2], out_elem_2);
          errors++;
        end
        if (out_elem_3 !== g.e[3]) begin
          $error("elem_3: expected %h, got %h", g.e[3], out_elem_3);
          errors++;
        end
        if (out_last_group !== g.last) begin
          $error("last_group: expected %0b, got %0b", g.last, out_last_group);
          errors++;
        end
        if (out_degenerate !== g.degen) begin
          $error("degenerate: expected %0b, got %0b", g.degen, out_degenerate);
          errors++;
        end
        if (g.degen && g.last) degen_seen++;
      end
    end
  end

  // Receiver stall: random, one long hold-off, one quiet stretch
  always @(posedge clk) begin
    if (!hold_done && groups_seen >= 40) begin
      hold_done <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= (hold_cnt > 1);
    end else if (out_quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 12);
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d groups pending", cycles, groups_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Stimulus
  initial begin
    dir_rows.push_back(mk(0, 0, 0, 0, 0, -65536, 0, 65536, 0, 0));
    dir_rows.push_back(mk(65536, 131072, -65536, 65536, 131072, -65536, 0, 65536, 0, 1));
    dir_rows.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    dir_rows.push_back(mk(0, 0, 0, 65536, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(0, 0, 0, 0, 65536, 0, 0, 196608, 0, 0));
    dir_rows.push_back(mk(0, 0, 0, 0, 65536, 0, 0, -65536, 0, 0));
    dir_rows.push_back(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                          32'h80000000, 32'h80000000, 32'h80000000,
                          32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0));
    dir_rows.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000,
                          32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                          32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0));
    dir_rows.push_back(mk(32'h80000000, 0, 0, 32'h7FFFFFFF, 0, 0,
                          0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0));
    dir_rows.push_back(mk(0, 0, 0, 1, 0, 0, 0, 1, 0, 0));
    dir_rows.push_back(mk(0, 0, 0, 1, 1, 1, 0, 0, 1, 0));
    dir_rows.push_back(mk(0, 0, 0, -1, 0, 0, 0, 0, 32'h80000000, 0));
    dir_rows.push_back(mk(100, -200, 300, 101, -199, 301, 32'h7FFFFFFF,
                          32'h7FFFFFFF, 32'h7FFFFFFF, 0));
    dir_rows.push_back(mk(65536, 65536, 65536, 131072, 196608, 262144,
                          32'h80000000, 32'h80000000, 32'h80000000, 0));
    dir_rows.push_back(mk(-5, 7, 11, 32'h7FFFFFF0, -32'h7FFFFFF0, 3, 1, -1, 1, 0));
    dir_rows.push_back(mk(32'h7FFFFFFF, 32'h80000000, 0, 32'h7FFFFFFF, 32'h80000000, 0,
                          65536, 0, 0, 1));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_view(dir_rows[i]);

    for (int n = 0; n < N_RANDOM; n++) begin
      in_quiet = (n >= 150 && n < 230);
      out_quiet = (n >= 240 && n < 300);
      if (n == 100) begin
        // sender pause until the pipeline drains
        in_valid <= 1'b0;
        while (groups_due.size() != 0) @(posedge clk);
      end
      send_view(rand_view());
    end
    in_valid <= 1'b0;

    while (groups_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d view requests, %0d matrix groups checked, %0d degenerate matrices",
             items_sent, groups_seen, degen_seen);
    $display("included full-range extremes, zero forward, collapsed side, and back-pressure");
    if (errors == 0 && groups_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
